// ===== design/nfsl_pkg.sv =====
// ----------------------------------------------------------------------------
// nfsl_pkg
// Shared types, widths and codes of the nearest fragment seed labeler.
// ----------------------------------------------------------------------------
`default_nettype none

package nfsl_pkg;

  // Table and field sizes
  localparam int MAX_FRAGMENTS = 64;
  localparam int LABEL_BITS    = 8;
  localparam int COORD_BITS    = 10;

  localparam int FRAG_IDX_W  = $clog2(MAX_FRAGMENTS);
  localparam int FRAG_CNT_W  = $clog2(MAX_FRAGMENTS + 1);
  localparam int LABEL_COUNT = 1 << LABEL_BITS;
  localparam int SEED_W      = 32;
  localparam int CNT_W       = SEED_W - LABEL_BITS;
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int DIST_W      = SQ_W + 2;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_METRIC = '0;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [FRAG_IDX_W-1:0] fidx_t;
  typedef logic [FRAG_CNT_W-1:0] fcnt_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SEED_W-1:0]     seed_t;
  typedef logic [1:0]            code_t;

  // Action codes
  localparam code_t ACT_CLEAR = 2'd0;
  localparam code_t ACT_LOAD  = 2'd1;
  localparam code_t ACT_QUERY = 2'd2;

  // Status codes
  localparam code_t ST_OK         = 2'd0;
  localparam code_t ST_TABLE_FULL = 2'd1;
  localparam code_t ST_EMPTY      = 2'd2;

  // Metric codes
  localparam code_t MET_EUCLID    = 2'd0;
  localparam code_t MET_MANHATTAN = 2'd1;
  localparam code_t MET_CHEBYSHEV = 2'd2;

  // One stored fragment
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    label_t label;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CNT_RD,
    S_CNT_WR,
    S_PUSH
  } state_t;

endpackage

`default_nettype wire

// ===== design/nfsl_if.sv =====
// ----------------------------------------------------------------------------
// nfsl_if
// Request and result channels of the nearest fragment seed labeler.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfsl_in_if;
  import nfsl_pkg::*;

  logic   valid;
  logic   ready;
  code_t  action;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  label_t point_label;

  modport source (output valid, action, point_x, point_y, point_z, point_label,
                  input ready);
  modport sink   (input valid, action, point_x, point_y, point_z, point_label,
                  output ready);
endinterface

interface nfsl_out_if;
  import nfsl_pkg::*;

  logic  valid;
  logic  ready;
  code_t status;
  seed_t seed_label;
  fidx_t nearest_index;

  modport source (output valid, status, seed_label, nearest_index, input ready);
  modport sink   (input valid, status, seed_label, nearest_index, output ready);
endinterface

`default_nettype wire

// ===== design/nearest_fragment_seed_labeler.sv =====
// ----------------------------------------------------------------------------
// nearest_fragment_seed_labeler
// Fragment table with nearest-point query and per-label use counters.
// ----------------------------------------------------------------------------
// One request is taken at a time. Clear, load and unused actions go from the
// accept straight to the hand-over to the output register, which waits for a
// free output slot. A query against a table of N fragments starts with the
// accept, then the table memory's single read port feeds entries into the
// four-stage distance pipeline one per cycle, the pipeline drains until it is
// seen empty, then the label counter memory takes a read and a write state,
// and the last state hands the result over once the output slot is free. A new request is
// taken as soon as the previous result sits in the output register, even if
// that result has not yet been taken. Clearing costs no sweep: each label
// counter has a valid bit, and the clear action drops all of them together.
`default_nettype none

module nearest_fragment_seed_labeler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  nfsl_in_if.sink                              in_req,
  nfsl_out_if.source                           out_res,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [nfsl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [nfsl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [nfsl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import nfsl_pkg::*;

  // Storage
  entry_t tbl_mem [MAX_FRAGMENTS];
  cnt_t   cnt_mem [LABEL_COUNT];

  // Control state
  state_t                 state_r, state_nxt;
  fcnt_t                  frag_cnt_r;
  fcnt_t                  issue_cnt_r;
  logic [LABEL_COUNT-1:0] cnt_valid_r;
  logic                   v1_r, v2_r, v3_r, v4_r;
  logic                   out_valid_r;
  code_t                  metric_r;

  // Request and pipeline payload
  coord_t seed_x_r, seed_y_r, seed_z_r;
  entry_t ent_r;
  fidx_t  idx1_r, idx2_r, idx3_r, idx4_r;
  label_t lab2_r, lab3_r, lab4_r;
  coord_t dx_r, dy_r, dz_r;
  sq_t    tx_r, ty_r, tz_r;
  dist_t  dist_r;
  dist_t  best_dist_r;
  fidx_t  best_idx_r;
  label_t best_lab_r;
  cnt_t   cnt_rd_r;
  code_t  res_status_r;
  seed_t  res_seed_r;
  fidx_t  res_index_r;
  code_t  out_status_r;
  seed_t  out_seed_r;
  fidx_t  out_index_r;

  // Combinational controls
  logic  accept;
  logic  slot_free;
  logic  issue;
  logic  scan_idle;
  logic  full;
  logic  push;
  logic  cnt_wr;
  logic  cfg_wr;
  logic  take_best;
  cnt_t  cnt_base;
  cnt_t  cnt_new;
  coord_t ad_x, ad_y, ad_z;
  sq_t   term_x, term_y, term_z;
  dist_t dist_val;
  sq_t   max_xy;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (cfg_paddr[CFG_ADDR_W-1:2] == REG_METRIC) begin
      cfg_prdata = CFG_DATA_W'(metric_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= MET_EUCLID;
    end else if (cfg_wr && cfg_paddr[CFG_ADDR_W-1:2] == REG_METRIC) begin
      metric_r <= code_t'(cfg_pwdata[1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_res.ready;
  assign full         = (frag_cnt_r == FRAG_CNT_W'(MAX_FRAGMENTS));
  assign issue        = (state_r == S_SCAN) && (issue_cnt_r != frag_cnt_r);
  assign scan_idle    = !v1_r && !v2_r && !v3_r && !v4_r;

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    cnt_wr    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.action == ACT_QUERY && frag_cnt_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_SCAN: begin
        if (!issue && scan_idle) begin
          state_nxt = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        cnt_wr    = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers: fill count, counter valid bits, scan pipeline valids
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_cnt_r  <= '0;
      cnt_valid_r <= '0;
      issue_cnt_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && in_req.action == ACT_CLEAR) begin
        frag_cnt_r  <= '0;
        cnt_valid_r <= '0;
      end else if (accept && in_req.action == ACT_LOAD && !full) begin
        frag_cnt_r <= frag_cnt_r + FRAG_CNT_W'(1);
      end
      if (cnt_wr) begin
        cnt_valid_r[best_lab_r] <= 1'b1;
      end
      if (accept) begin
        issue_cnt_r <= '0;
      end else if (issue) begin
        issue_cnt_r <= issue_cnt_r + FRAG_CNT_W'(1);
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fragment table: append on load, read one entry per scan cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && in_req.action == ACT_LOAD && !full) begin
      tbl_mem[frag_cnt_r[FRAG_IDX_W-1:0]] <= '{x: in_req.point_x, y: in_req.point_y,
                                               z: in_req.point_z,
                                               label: in_req.point_label};
    end
    if (issue) begin
      ent_r <= tbl_mem[issue_cnt_r[FRAG_IDX_W-1:0]];
    end
  end

  // Hold the seed voxel for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      seed_x_r <= in_req.point_x;
      seed_y_r <= in_req.point_y;
      seed_z_r <= in_req.point_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Distance unit: absolute differences, per-axis terms, combine, compare
  // ---------------------------------------------------------------------------
  assign ad_x = (ent_r.x > seed_x_r) ? ent_r.x - seed_x_r : seed_x_r - ent_r.x;
  assign ad_y = (ent_r.y > seed_y_r) ? ent_r.y - seed_y_r : seed_y_r - ent_r.y;
  assign ad_z = (ent_r.z > seed_z_r) ? ent_r.z - seed_z_r : seed_z_r - ent_r.z;

  // Square each axis for Euclidean, pass the difference through otherwise
  always_comb begin
    if (metric_r == MET_EUCLID) begin
      term_x = sq_t'(dx_r) * sq_t'(dx_r);
      term_y = sq_t'(dy_r) * sq_t'(dy_r);
      term_z = sq_t'(dz_r) * sq_t'(dz_r);
    end else begin
      term_x = sq_t'(dx_r);
      term_y = sq_t'(dy_r);
      term_z = sq_t'(dz_r);
    end
  end

  // Sum for Euclidean and Manhattan, maximum for Chebyshev, zero for the unused code
  assign max_xy = (ty_r > tx_r) ? ty_r : tx_r;

  always_comb begin
    unique case (metric_r)
      MET_EUCLID, MET_MANHATTAN: begin
        dist_val = dist_t'(tx_r) + dist_t'(ty_r) + dist_t'(tz_r);
      end
      MET_CHEBYSHEV: begin
        dist_val = (tz_r > max_xy) ? dist_t'(tz_r) : dist_t'(max_xy);
      end
      default: begin
        dist_val = '0;
      end
    endcase
  end

  // The first entry always seeds the best; later ones must be strictly nearer
  assign take_best = v4_r && (idx4_r == '0 || dist_r < best_dist_r);

  always_ff @(posedge clk) begin
    idx1_r <= issue_cnt_r[FRAG_IDX_W-1:0];
    dx_r   <= ad_x;
    dy_r   <= ad_y;
    dz_r   <= ad_z;
    idx2_r <= idx1_r;
    lab2_r <= ent_r.label;
    tx_r   <= term_x;
    ty_r   <= term_y;
    tz_r   <= term_z;
    idx3_r <= idx2_r;
    lab3_r <= lab2_r;
    dist_r <= dist_val;
    idx4_r <= idx3_r;
    lab4_r <= lab3_r;
    if (take_best) begin
      best_dist_r <= dist_r;
      best_idx_r  <= idx4_r;
      best_lab_r  <= lab4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Label use counters: read, then write back the raised count
  // ---------------------------------------------------------------------------
  assign cnt_base = cnt_valid_r[best_lab_r] ? cnt_rd_r : '0;
  assign cnt_new  = cnt_base + cnt_t'(1);

  always_ff @(posedge clk) begin
    if (state_r == S_CNT_RD) begin
      cnt_rd_r <= cnt_mem[best_lab_r];
    end
    if (cnt_wr) begin
      cnt_mem[best_lab_r] <= cnt_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Pending result, then hand it to the output register when free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      res_seed_r <= '0;
      unique case (in_req.action)
        ACT_LOAD: begin
          if (full) begin
            res_status_r <= ST_TABLE_FULL;
            res_index_r  <= '0;
          end else begin
            res_status_r <= ST_OK;
            res_index_r  <= frag_cnt_r[FRAG_IDX_W-1:0];
          end
        end
        ACT_QUERY: begin
          res_status_r <= (frag_cnt_r == '0) ? ST_EMPTY : ST_OK;
          res_index_r  <= '0;
        end
        default: begin
          res_status_r <= ST_OK;
          res_index_r  <= '0;
        end
      endcase
    end else if (cnt_wr) begin
      res_status_r <= ST_OK;
      res_seed_r   <= {cnt_new, best_lab_r};
      res_index_r  <= best_idx_r;
    end
    if (push) begin
      out_status_r <= res_status_r;
      out_seed_r   <= res_seed_r;
      out_index_r  <= res_index_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_status_r;
  assign out_res.seed_label    = out_seed_r;
  assign out_res.nearest_index = out_index_r;

endmodule

`default_nettype wire
